// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLSU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slsu check failed");

// next-cycle implication
`define SLSU_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slsu check failed");

`endif

// File: hw/rtl/slsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slsu_pkg;

   localparam int DEPTH_DEF      = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int LABEL_BITS_DEF = 32;

   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int KEY_W    = 32;
   localparam int WORD_W   = 32;
   localparam int MASK_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   localparam int CSEL_W   = 3;

   localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
   localparam logic [OP_W-1:0] OP_POP        = 3'd1;
   localparam logic [OP_W-1:0] OP_READ       = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND_KEY   = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND_VALUE = 3'd4;
   localparam logic [OP_W-1:0] OP_UPDATE     = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // cursor next-value selects
   localparam logic [CSEL_W-1:0] CUR_HOLD      = 3'd0;
   localparam logic [CSEL_W-1:0] CUR_COUNT     = 3'd1;
   localparam logic [CSEL_W-1:0] CUR_COUNT_INC = 3'd2;
   localparam logic [CSEL_W-1:0] CUR_POS       = 3'd3;
   localparam logic [CSEL_W-1:0] CUR_DEC       = 3'd4;

   // field select bits, shared by write mask, write enables and merge
   localparam int MASK_KEY_BIT   = 0;
   localparam int MASK_VALUE_BIT = 1;
   localparam int MASK_LABEL_BIT = 2;
   localparam logic [MASK_W-1:0] MASK_NONE = 3'b000;
   localparam logic [MASK_W-1:0] MASK_ALL  = 3'b111;

   typedef struct packed {
      logic                req_load;
      logic [CSEL_W-1:0]   cursor_sel;
      logic                rd_en;
      logic [MASK_W-1:0]   wr_en;
      logic                count_inc;
      logic                count_dec;
      logic                out_load;
      logic                out_hit;
      logic [STATUS_W-1:0] out_status;
      logic [MASK_W-1:0]   merge;
      logic                out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [MASK_W-1:0] mask;
      logic              full;
      logic              empty;
      logic              pos_ok;
      logic              cursor_one;
      logic              key_match;
      logic              value_match;
      logic              out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/slsu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface slsu_req_if;
   logic                              valid;
   logic                              ready;
   logic [slsu_pkg::OP_W-1:0]         operation;
   logic [slsu_pkg::POS_W-1:0]        position;
   logic signed [slsu_pkg::KEY_W-1:0] entry_key;
   logic [slsu_pkg::WORD_W-1:0]       entry_value;
   logic [slsu_pkg::WORD_W-1:0]       entry_label;
   logic [slsu_pkg::MASK_W-1:0]       write_mask;

   modport source (
      output valid, operation, position, entry_key, entry_value, entry_label, write_mask,
      input  ready
   );
   modport sink (
      input  valid, operation, position, entry_key, entry_value, entry_label, write_mask,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/slsu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface slsu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [slsu_pkg::STATUS_W-1:0]     status;
   logic [slsu_pkg::POS_W-1:0]        found_position;
   logic signed [slsu_pkg::KEY_W-1:0] found_key;
   logic [slsu_pkg::WORD_W-1:0]       found_value;
   logic [slsu_pkg::WORD_W-1:0]       found_label;
   logic [slsu_pkg::COUNT_W-1:0]      entry_count;
   logic                              last;

   modport source (
      output valid, status, found_position, found_key, found_value, found_label,
             entry_count, last,
      input  ready
   );
   modport sink (
      input  valid, status, found_position, found_key, found_value, found_label,
             entry_count, last,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/slsu_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module slsu_dpath #(
   parameter int DEPTH      = slsu_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = slsu_pkg::VALUE_BITS_DEF,
   parameter int LABEL_BITS = slsu_pkg::LABEL_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire slsu_pkg::dp_cmd_type              cmd,
   output slsu_pkg::dp_status_type                sts,
   input  wire logic [slsu_pkg::OP_W-1:0]         req_operation,
   input  wire logic [slsu_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [slsu_pkg::KEY_W-1:0] req_entry_key,
   input  wire logic [slsu_pkg::WORD_W-1:0]       req_entry_value,
   input  wire logic [slsu_pkg::WORD_W-1:0]       req_entry_label,
   input  wire logic [slsu_pkg::MASK_W-1:0]       req_write_mask,
   slsu_rsp_if.source                             rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int XW = (CW > slsu_pkg::POS_W) ? CW : slsu_pkg::POS_W;

   // latched request
   logic [slsu_pkg::OP_W-1:0]         op_ff, op_in;
   logic [slsu_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic signed [slsu_pkg::KEY_W-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0]             value_ff, value_in;
   logic [LABEL_BITS-1:0]             label_ff, label_in;
   logic [slsu_pkg::MASK_W-1:0]       mask_ff, mask_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] addr;

   logic signed [slsu_pkg::KEY_W-1:0] key_mem [DEPTH];
   logic [VALUE_BITS-1:0]             value_mem [DEPTH];
   logic [LABEL_BITS-1:0]             label_mem [DEPTH];
   logic signed [slsu_pkg::KEY_W-1:0] key_rd_ff;
   logic [VALUE_BITS-1:0]             value_rd_ff;
   logic [LABEL_BITS-1:0]             label_rd_ff;

   logic signed [slsu_pkg::KEY_W-1:0] merge_key;
   logic [VALUE_BITS-1:0]             merge_value;
   logic [LABEL_BITS-1:0]             merge_label;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [slsu_pkg::STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [slsu_pkg::POS_W-1:0]        out_pos_ff, out_pos_in;
   logic signed [slsu_pkg::KEY_W-1:0] out_key_ff, out_key_in;
   logic [slsu_pkg::WORD_W-1:0]       out_value_ff, out_value_in;
   logic [slsu_pkg::WORD_W-1:0]       out_label_ff, out_label_in;
   logic [slsu_pkg::COUNT_W-1:0]      out_count_ff, out_count_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_free;

   always_comb begin
      op_in    = op_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      value_in = value_ff;
      label_in = label_ff;
      mask_in  = mask_ff;
      if (cmd.req_load) begin
         op_in    = req_operation;
         pos_in   = req_position;
         key_in   = req_entry_key;
         value_in = VALUE_BITS'(req_entry_value);
         label_in = LABEL_BITS'(req_entry_label);
         mask_in  = req_write_mask;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      label_ff <= label_in;
      mask_ff  <= mask_in;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      case (cmd.cursor_sel)
         slsu_pkg::CUR_COUNT:     cursor_in = count_ff;
         slsu_pkg::CUR_COUNT_INC: cursor_in = count_ff + CW'(1);
         slsu_pkg::CUR_POS:       cursor_in = CW'(pos_ff);
         slsu_pkg::CUR_DEC:       cursor_in = cursor_ff - CW'(1);
         default:                 cursor_in = cursor_ff;
      endcase
   end

   // one address for read and write: the entry under the new cursor
   assign addr = AW'(cursor_in - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en[slsu_pkg::MASK_KEY_BIT]) begin
         key_mem[addr] <= key_ff;
      end
      if (cmd.wr_en[slsu_pkg::MASK_VALUE_BIT]) begin
         value_mem[addr] <= value_ff;
      end
      if (cmd.wr_en[slsu_pkg::MASK_LABEL_BIT]) begin
         label_mem[addr] <= label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         key_rd_ff   <= key_mem[addr];
         value_rd_ff <= value_mem[addr];
         label_rd_ff <= label_mem[addr];
      end
   end

   // fields taken from the request replace the read data (push, update)
   assign merge_key   = cmd.merge[slsu_pkg::MASK_KEY_BIT]   ? key_ff   : key_rd_ff;
   assign merge_value = cmd.merge[slsu_pkg::MASK_VALUE_BIT] ? value_ff : value_rd_ff;
   assign merge_label = cmd.merge[slsu_pkg::MASK_LABEL_BIT] ? label_ff : label_rd_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_pos_in    = out_pos_ff;
      out_key_in    = out_key_ff;
      out_value_in  = out_value_ff;
      out_label_in  = out_label_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         out_status_in = cmd.out_status;
         out_count_in  = slsu_pkg::COUNT_W'(count_ff);
         out_last_in   = cmd.out_last;
         if (cmd.out_hit) begin
            out_pos_in   = slsu_pkg::POS_W'(cursor_ff);
            out_key_in   = merge_key;
            out_value_in = slsu_pkg::WORD_W'(merge_value);
            out_label_in = slsu_pkg::WORD_W'(merge_label);
         end else begin
            out_pos_in   = '0;
            out_key_in   = '0;
            out_value_in = '0;
            out_label_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_pos_ff    <= out_pos_in;
      out_key_ff    <= out_key_in;
      out_value_ff  <= out_value_in;
      out_label_ff  <= out_label_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.found_position = out_pos_ff;
   assign rsp_ch.found_key      = out_key_ff;
   assign rsp_ch.found_value    = out_value_ff;
   assign rsp_ch.found_label    = out_label_ff;
   assign rsp_ch.entry_count    = out_count_ff;
   assign rsp_ch.last           = out_last_ff;

   always_comb begin
      sts.op          = op_ff;
      sts.mask        = mask_ff;
      sts.full        = (count_ff == CW'(DEPTH));
      sts.empty       = (count_ff == '0);
      sts.pos_ok      = (pos_ff != '0) && (XW'(pos_ff) <= XW'(count_ff));
      sts.cursor_one  = (cursor_ff == CW'(1));
      sts.key_match   = (key_rd_ff == key_ff);
      sts.value_match = (value_rd_ff == value_ff);
      sts.out_free    = out_free;
   end

endmodule

`default_nettype wire

// File: hw/rtl/slsu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slsu_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire slsu_pkg::dp_status_type sts,
   output slsu_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SEND   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DUMP   = 3'd4;
   localparam logic [2:0] S_MISS   = 3'd5;
   localparam logic [2:0] S_FULL   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       hit;

   assign hit = (sts.op == slsu_pkg::OP_FIND_KEY) ? sts.key_match : sts.value_match;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               slsu_pkg::OP_PUSH: begin
                  if (sts.full) begin
                     state_in = S_FULL;
                  end else begin
                     cmd.cursor_sel = slsu_pkg::CUR_COUNT_INC;
                     cmd.wr_en      = slsu_pkg::MASK_ALL;
                     cmd.count_inc  = 1'b1;
                     state_in       = S_SEND;
                  end
               end
               slsu_pkg::OP_POP: begin
                  if (sts.empty) begin
                     state_in = S_MISS;
                  end else begin
                     cmd.cursor_sel = slsu_pkg::CUR_COUNT;
                     cmd.rd_en      = 1'b1;
                     cmd.count_dec  = 1'b1;
                     state_in       = S_SEND;
                  end
               end
               slsu_pkg::OP_READ, slsu_pkg::OP_UPDATE: begin
                  if (!sts.pos_ok) begin
                     state_in = S_MISS;
                  end else begin
                     // update reads the old entry and merges on the way out
                     cmd.cursor_sel = slsu_pkg::CUR_POS;
                     cmd.rd_en      = 1'b1;
                     if (sts.op == slsu_pkg::OP_UPDATE) begin
                        cmd.wr_en = sts.mask;
                     end
                     state_in = S_SEND;
                  end
               end
               slsu_pkg::OP_FIND_KEY, slsu_pkg::OP_FIND_VALUE, slsu_pkg::OP_DUMP: begin
                  if (sts.empty) begin
                     state_in = S_MISS;
                  end else begin
                     cmd.cursor_sel = slsu_pkg::CUR_COUNT;
                     cmd.rd_en      = 1'b1;
                     state_in       = (sts.op == slsu_pkg::OP_DUMP) ? S_DUMP : S_SCAN;
                  end
               end
               default: state_in = S_MISS;
            endcase
         end
         S_SEND: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_hit    = 1'b1;
               cmd.out_status = slsu_pkg::ST_OK;
               cmd.out_last   = 1'b1;
               if (sts.op == slsu_pkg::OP_PUSH) begin
                  cmd.merge = slsu_pkg::MASK_ALL;
               end else if (sts.op == slsu_pkg::OP_UPDATE) begin
                  cmd.merge = sts.mask;
               end else begin
                  cmd.merge = slsu_pkg::MASK_NONE;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // compare the entry read last cycle; on no match above the bottom entry, fetch the one below it
            if (hit) begin
               state_in = S_SEND;
            end else if (sts.cursor_one) begin
               state_in = S_MISS;
            end else begin
               cmd.cursor_sel = slsu_pkg::CUR_DEC;
               cmd.rd_en      = 1'b1;
            end
         end
         S_DUMP: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_hit    = 1'b1;
               cmd.out_status = slsu_pkg::ST_OK;
               cmd.out_last   = sts.cursor_one;
               if (sts.cursor_one) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.cursor_sel = slsu_pkg::CUR_DEC;
                  cmd.rd_en      = 1'b1;
               end
            end
         end
         S_MISS, S_FULL: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = (state_ff == S_FULL) ? slsu_pkg::ST_FULL : slsu_pkg::ST_MISS;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/searchable_lifo_stack_unit.sv
// Bounded LIFO stack of DEPTH entries (key, value word, label word) with
// push, pop, read and masked update by 1-based position, search by key or
// value (topmost match wins) and a top-down dump. Requests are handled one at
// a time; the result register lets a new request enter while the previous
// result is still waiting. Push, pop, read, update and every request refused
// at decode (full, empty, bad position, unused code) are latched, decoded and
// then loaded into the result register once it is free. A search reads the
// entries from the top down one at a time, bound by the single read port of
// the entry memories, and stops at the first match or after the bottom entry.
// A dump delivers one entry per cycle while the result side keeps taking them.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module searchable_lifo_stack_unit #(
   parameter int DEPTH      = slsu_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = slsu_pkg::VALUE_BITS_DEF,
   parameter int LABEL_BITS = slsu_pkg::LABEL_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   slsu_req_if.sink   req_ch,
   slsu_rsp_if.source rsp_ch
);

   slsu_pkg::dp_cmd_type    cmd;
   slsu_pkg::dp_status_type sts;

   slsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   slsu_dpath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .LABEL_BITS (LABEL_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_ch.operation),
      .req_position    (req_ch.position),
      .req_entry_key   (req_ch.entry_key),
      .req_entry_value (req_ch.entry_value),
      .req_entry_label (req_ch.entry_label),
      .req_write_mask  (req_ch.write_mask),
      .rsp_ch          (rsp_ch)
   );

   `SLSU_ASSERT_IMP(a_load_when_free, clock, reset, cmd.out_load, sts.out_free)
   `SLSU_ASSERT_IMP(a_no_push_full, clock, reset, cmd.count_inc, !sts.full)
   `SLSU_ASSERT_IMP(a_no_pop_empty, clock, reset, cmd.count_dec, !sts.empty)
   `SLSU_ASSERT_NXT(a_one_request, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import slsu_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 72;

   typedef struct {
      logic [OP_W-1:0]          operation;
      logic [POS_W-1:0]         position;
      logic signed [KEY_W-1:0]  entry_key;
      logic [WORD_W-1:0]        entry_value;
      logic [WORD_W-1:0]        entry_label;
      logic [MASK_W-1:0]        write_mask;
   } stack_req_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic [POS_W-1:0]         found_position;
      logic signed [KEY_W-1:0]  found_key;
      logic [WORD_W-1:0]        found_value;
      logic [WORD_W-1:0]        found_label;
      logic [COUNT_W-1:0]       entry_count;
      logic                     last;
   } stack_result_type;

   typedef struct {
      stack_req_type    req;
      int               reps;
      bit               typed;
      stack_result_type want;
   } stack_row_type;

   logic clock;
   logic reset;

   slsu_req_if req_ch ();
   slsu_rsp_if rsp_ch ();

   searchable_lifo_stack_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the stack
   logic signed [KEY_W-1:0] model_key   [STACK_DEPTH];
   logic [WORD_W-1:0]       model_value [STACK_DEPTH];
   logic [WORD_W-1:0]       model_label [STACK_DEPTH];
   int                      model_fill = 0;
   int                      peak_fill = 0;

   stack_result_type expected_results [$];
   stack_row_type    stack_table [$];
   stack_row_type    pending_rows [$];
   stack_row_type    cur_row;

   int random_left = 0;
   int random_made = 0;
   bit growing = 1'b0;
   bit req_in_flight = 1'b0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int reqs_done = 0;
   int results_done = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_PUSH;
      req_ch.position = '0;
      req_ch.entry_key = '0;
      req_ch.entry_value = '0;
      req_ch.entry_label = '0;
      req_ch.write_mask = MASK_NONE;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic stack_result_type entry_result(input int slot, input bit is_last);
      stack_result_type r;
      r.status = ST_OK;
      r.found_position = POS_W'(slot + 1);
      r.found_key = model_key[slot];
      r.found_value = model_value[slot];
      r.found_label = model_label[slot];
      r.entry_count = COUNT_W'(model_fill);
      r.last = is_last;
      return r;
   endfunction

   function automatic stack_result_type no_entry(input logic [STATUS_W-1:0] st);
      stack_result_type r;
      r.status = st;
      r.found_position = '0;
      r.found_key = '0;
      r.found_value = '0;
      r.found_label = '0;
      r.entry_count = COUNT_W'(model_fill);
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_stack_op(input stack_req_type r);
      int slot;
      bit hit;
      slot = int'(r.position) - 1;
      hit = 1'b0;
      case (r.operation)
         OP_PUSH: begin
            if (model_fill >= STACK_DEPTH) begin
               expected_results.push_back(no_entry(ST_FULL));
            end else begin
               model_key[model_fill] = r.entry_key;
               model_value[model_fill] = r.entry_value;
               model_label[model_fill] = r.entry_label;
               model_fill++;
               expected_results.push_back(entry_result(model_fill - 1, 1'b1));
            end
         end
         OP_POP: begin
            if (model_fill == 0) begin
               expected_results.push_back(no_entry(ST_MISS));
            end else begin
               model_fill--;
               expected_results.push_back(entry_result(model_fill, 1'b1));
            end
         end
         OP_READ, OP_UPDATE: begin
            if (r.position == 0 || r.position > model_fill) begin
               expected_results.push_back(no_entry(ST_MISS));
            end else begin
               if (r.operation == OP_UPDATE) begin
                  if (r.write_mask[MASK_KEY_BIT]) model_key[slot] = r.entry_key;
                  if (r.write_mask[MASK_VALUE_BIT]) model_value[slot] = r.entry_value;
                  if (r.write_mask[MASK_LABEL_BIT]) model_label[slot] = r.entry_label;
               end
               expected_results.push_back(entry_result(slot, 1'b1));
            end
         end
         OP_FIND_KEY, OP_FIND_VALUE: begin
            // topmost match wins
            for (int i = model_fill - 1; i >= 0 && !hit; i--) begin
               if (r.operation == OP_FIND_KEY ? model_key[i] == r.entry_key
                                              : model_value[i] == r.entry_value) begin
                  hit = 1'b1;
                  expected_results.push_back(entry_result(i, 1'b1));
               end
            end
            if (!hit) expected_results.push_back(no_entry(ST_MISS));
         end
         OP_DUMP: begin
            if (model_fill == 0) begin
               expected_results.push_back(no_entry(ST_MISS));
            end else begin
               for (int i = model_fill - 1; i >= 0; i--)
                  expected_results.push_back(entry_result(i, i == 0));
            end
         end
         default: begin
            expected_results.push_back(no_entry(ST_MISS));
         end
      endcase
      if (model_fill > peak_fill) peak_fill = model_fill;
   endtask

   task automatic accept_request(input stack_row_type row_in);
      int n0;
      n0 = expected_results.size();
      predict_stack_op(row_in.req);
      // typed-in rows replace the prediction, the shadow state still moves
      if (row_in.typed) begin
         while (expected_results.size() > n0)
            expected_results.delete(expected_results.size() - 1);
         expected_results.push_back(row_in.want);
      end
      reqs_done++;
   endtask

   function automatic stack_req_type make_random_req();
      stack_req_type r;
      int w;
      int push_w;
      int rest;
      // alternate between filling and draining so the whole depth gets used
      if (random_made % 48 == 0) growing = !growing;
      random_made++;
      push_w = growing ? 40 : 12;
      w = $urandom_range(99);
      if (w < push_w) begin
         r.operation = OP_PUSH;
      end else if (w < 50) begin
         r.operation = OP_POP;
      end else begin
         rest = w - 50;
         if (rest < 12) r.operation = OP_READ;
         else if (rest < 23) r.operation = OP_FIND_KEY;
         else if (rest < 33) r.operation = OP_FIND_VALUE;
         else if (rest < 44) r.operation = OP_UPDATE;
         else if (rest < 48) r.operation = OP_DUMP;
         else r.operation = OP_UNUSED;
      end
      if ($urandom_range(4) != 0 && model_fill > 0)
         r.position = POS_W'($urandom_range(model_fill, 1));
      else
         r.position = POS_W'($urandom_range(63));
      case ($urandom_range(9))
         0, 1, 2, 3, 4: r.entry_key = (model_fill > 0) ?
                           model_key[$urandom_range(model_fill - 1)] : $urandom;
         5: r.entry_key = 32'h8000_0000;
         6: r.entry_key = 32'h7fff_ffff;
         7: r.entry_key = $urandom_range(3);
         default: r.entry_key = $urandom;
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3, 4: r.entry_value = (model_fill > 0) ?
                           model_value[$urandom_range(model_fill - 1)] : $urandom;
         5: r.entry_value = 32'hffff_ffff;
         6: r.entry_value = '0;
         7: r.entry_value = $urandom_range(3);
         default: r.entry_value = $urandom;
      endcase
      r.entry_label = $urandom;
      r.write_mask = MASK_W'($urandom_range(7));
      return r;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] value,
                          input logic [WORD_W-1:0] label, input logic [MASK_W-1:0] mask,
                          input int reps, input bit typed, input logic [STATUS_W-1:0] st,
                          input logic [POS_W-1:0] fpos, input logic [KEY_W-1:0] fkey,
                          input logic [WORD_W-1:0] fval, input logic [WORD_W-1:0] flab,
                          input logic [COUNT_W-1:0] cnt);
      stack_row_type row_new;
      row_new.req.operation = op;
      row_new.req.position = pos;
      row_new.req.entry_key = key;
      row_new.req.entry_value = value;
      row_new.req.entry_label = label;
      row_new.req.write_mask = mask;
      row_new.reps = reps;
      row_new.typed = typed;
      row_new.want.status = st;
      row_new.want.found_position = fpos;
      row_new.want.found_key = fkey;
      row_new.want.found_value = fval;
      row_new.want.found_label = flab;
      row_new.want.entry_count = cnt;
      row_new.want.last = 1'b1;
      stack_table.push_back(row_new);
   endtask

   task automatic wait_drained();
      while (pending_rows.size() != 0 || random_left != 0 || req_in_flight ||
             expected_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic void cmp_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request side
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            accept_request(cur_row);
            req_in_flight = 1'b0;
         end
         if (req_in_flight) begin
            // hold the item until its transfer
         end else if ((pending_rows.size() > 0 || random_left > 0) &&
                      $urandom_range(99) >= send_idle_pct) begin
            if (pending_rows.size() > 0) begin
               cur_row = pending_rows.pop_front();
            end else begin
               cur_row.req = make_random_req();
               cur_row.typed = 1'b0;
               cur_row.reps = 1;
               random_left--;
            end
            req_ch.operation <= cur_row.req.operation;
            req_ch.position <= cur_row.req.position;
            req_ch.entry_key <= cur_row.req.entry_key;
            req_ch.entry_value <= cur_row.req.entry_value;
            req_ch.entry_label <= cur_row.req.entry_label;
            req_ch.write_mask <= cur_row.req.write_mask;
            req_ch.valid <= 1'b1;
            req_in_flight = 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin : take_rsp
      stack_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_done++;
            if (expected_results.size() == 0) begin
               $error("result with nothing pending, status %0d position %0d",
                      rsp_ch.status, rsp_ch.found_position);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               cmp_field("status", want.status, rsp_ch.status);
               cmp_field("found_position", want.found_position, rsp_ch.found_position);
               cmp_field("found_key", want.found_key, rsp_ch.found_key);
               cmp_field("found_value", want.found_value, rsp_ch.found_value);
               cmp_field("found_label", want.found_label, rsp_ch.found_label);
               cmp_field("entry_count", want.entry_count, rsp_ch.entry_count);
               cmp_field("last", want.last, rsp_ch.last);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no transfer for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : run_phases
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed table: rows with a typed-in answer are the easy-to-read ones
      add_row(OP_POP, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_DUMP, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_READ, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_FIND_KEY, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_UNUSED, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_UPDATE, 1, 1, 1, 1, MASK_ALL, 1, 1, ST_MISS, 0, 0, 0, 0, 0);
      add_row(OP_PUSH, 0, 32'h8000_0000, 0, 32'hffff_ffff, MASK_NONE, 1,
              1, ST_OK, 1, 32'h8000_0000, 0, 32'hffff_ffff, 1);
      add_row(OP_PUSH, 0, 32'h7fff_ffff, 32'hffff_ffff, 0, MASK_NONE, 1,
              1, ST_OK, 2, 32'h7fff_ffff, 32'hffff_ffff, 0, 2);
      add_row(OP_PUSH, 0, 32'hffff_ffff, 5, 32'ha5a5_a5a5, MASK_NONE, 1,
              1, ST_OK, 3, 32'hffff_ffff, 5, 32'ha5a5_a5a5, 3);
      add_row(OP_READ, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_READ, 4, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_READ, 63, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_READ, 1, 0, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_FIND_KEY, 0, 32'h7fff_ffff, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_FIND_VALUE, 0, 0, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_FIND_VALUE, 0, 0, 12345, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_FIND_KEY, 0, 5, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_UPDATE, 2, 1, 1, 1, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_UPDATE, 2, 32'h1234, 5, 32'h55aa_55aa, MASK_ALL, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_UPDATE, 3, 32'h1234, 32'hdead, 32'h0f0f_0f0f, 3'b101, 1,
              0, ST_OK, 0, 0, 0, 0, 0);
      // duplicates at positions 2 and 3, the upper one must come back
      add_row(OP_FIND_KEY, 0, 32'h1234, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_FIND_VALUE, 0, 0, 5, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_UPDATE, 32, 0, 0, 0, MASK_ALL, 1, 1, ST_MISS, 0, 0, 0, 0, 3);
      add_row(OP_DUMP, 0, 0, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_PUSH, 0, 32'h100, 32'h200, 32'h300, MASK_NONE, STACK_DEPTH - 3,
              0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_PUSH, 0, 1, 1, 1, MASK_NONE, 1, 1, ST_FULL, 0, 0, 0, 0, STACK_DEPTH);
      add_row(OP_READ, 32, 0, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_UPDATE, 33, 0, 0, 0, MASK_ALL, 1, 1, ST_MISS, 0, 0, 0, 0, STACK_DEPTH);
      add_row(OP_DUMP, 0, 0, 0, 0, MASK_NONE, 1, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_POP, 0, 0, 0, 0, MASK_NONE, STACK_DEPTH, 0, ST_OK, 0, 0, 0, 0, 0);
      add_row(OP_POP, 0, 0, 0, 0, MASK_NONE, 1, 1, ST_MISS, 0, 0, 0, 0, 0);

      foreach (stack_table[i])
         repeat (stack_table[i].reps) pending_rows.push_back(stack_table[i]);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         random_left = RANDOM_PER_PHASE;
         wait_drained();
      end

      // let any stray result show up
      recv_stall_pct = 0;
      repeat (STACK_DEPTH + 10) @(negedge clock);

      $display("%0d requests and %0d results checked under four handshake pressure mixes",
               reqs_done, results_done);
      $display("stack fill peaked at %0d of %0d entries", peak_fill, STACK_DEPTH);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/slsu_pkg.sv
hw/rtl/slsu_req_if.sv
hw/rtl/slsu_rsp_if.sv
hw/rtl/slsu_dpath.sv
hw/rtl/slsu_ctrl.sv
hw/rtl/searchable_lifo_stack_unit.sv
tb/tb_top.sv
